// ===== sv/comment_blanking_filter_macros.svh =====
// ----------------------------------------------------------------------------
// comment blanking filter assertion macros
// shared concurrent check forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef COMMENT_BLANKING_FILTER_MACROS_SVH
`define COMMENT_BLANKING_FILTER_MACROS_SVH

// same-cycle implication
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbf_pkg
// types, character constants and the per-byte classifier of the filter
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// result queue depth and pointer width
	localparam int QDEPTH = 3;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_LINE,
		MODE_BLOCK,
		MODE_CLOSE
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_req_t;

	// results produced by one accepted request, item0 goes out first
	typedef struct packed {
		logic [1:0] cnt;
		out_req_t   item0;
		out_req_t   item1;
	} push_t;

	typedef struct packed {
		logic       held_valid;
		scan_mode_t mode;
	} scan_stat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		scan_mode_t mode;
	} cls_t;

	function automatic cls_t classify(scan_mode_t mode, logic [7:0] cur,
			logic [7:0] nxt, logic has_next);
		cls_t r;
		r.out_byte = cur;
		r.mode     = mode;
		unique case (mode)
			MODE_TEXT: begin
				if (cur == CH_SLASH && has_next && nxt == CH_SLASH) begin
					r.out_byte = CH_SPACE;
					r.mode     = MODE_LINE;
				end else if (cur == CH_SLASH && has_next && nxt == CH_STAR) begin
					r.out_byte = CH_SPACE;
					r.mode     = MODE_BLOCK;
				end
			end
			MODE_LINE: begin
				if (cur == CH_LF || cur == CH_CR) begin
					r.mode = MODE_TEXT;
				end else begin
					r.out_byte = CH_SPACE;
				end
			end
			MODE_BLOCK: begin
				r.out_byte = CH_SPACE;
				if (cur == CH_STAR && has_next && nxt == CH_SLASH) begin
					r.mode = MODE_CLOSE;
				end
			end
			MODE_CLOSE: begin
				r.out_byte = CH_SPACE;
				r.mode     = MODE_TEXT;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== sv/comment_blanking_filter.sv =====
// ----------------------------------------------------------------------------
// comment_blanking_filter
// blanks line and block comments of a byte stream to spaces, length preserved
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready       | payload            | fields
//  --------+-------------+-------------+--------------------+------------------
//  raw     | raw_valid   | raw_ready   | raw   (in_req_t)   | in_byte, in_last
//  clean   | clean_valid | clean_ready | clean (out_req_t)  | out_byte, out_last
//
//  one raw request is taken per cycle while raw_ready is high; a byte leaves
//  one request later, once its lookahead byte has arrived, and the final byte
//  of a buffer flushes the held byte along with itself, two results at once
//  the three-entry result queue sets the pace: raw_ready is high while it
//  holds at most one result, so a stall on clean backs up into raw_ready
//  reset clears the lookahead, the comment mode and the queue pointers
//
`include "comment_blanking_filter_macros.svh"

module comment_blanking_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_ready,
	input  cbf_pkg::in_req_t  raw,
	output logic              clean_valid,
	input  logic              clean_ready,
	output cbf_pkg::out_req_t clean
);
	import cbf_pkg::*;

	logic       fire;
	push_t      push;
	scan_stat_t stat;
	logic       space;
	logic [1:0] level;

	// request taken when the queue can absorb both possible results
	assign raw_ready = space;
	assign fire      = raw_valid && raw_ready;

	// lookahead stage: classifies the held byte against the new one and,
	// on the final byte, the final byte itself
	cbf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.raw    (raw),
		.push   (push),
		.stat   (stat)
	);

	// result queue: decouples the scan stage from clean-side stalls
	cbf_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.space       (space),
		.level       (level),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean       (clean)
	);

	// final byte always returns the scanner to an empty, normal-text state
	`CBF_ASSERT_NEXT(a_last_resets_scan, fire && raw.in_last, !stat.held_valid && stat.mode == MODE_TEXT, "scan state not cleared after final byte")

	// a request that flushes two results leaves at least two queued
	`CBF_ASSERT_NEXT(a_flush_two, fire && raw.in_last && stat.held_valid, level >= 2'd2, "flush lost a result")

	// any request with a held byte produces a result on the next cycle
	`CBF_ASSERT_NEXT(a_held_emits, fire && stat.held_valid, clean_valid, "held byte produced no result")

	// push count stays consistent with the scan state
	`CBF_ASSERT_NOW(a_push_cnt, push.cnt == 2'd2, fire && stat.held_valid && raw.in_last, "double push without flush")

endmodule

// ===== sv/cbf_scan.sv =====
// ----------------------------------------------------------------------------
// cbf_scan
// lookahead register and comment mode tracking, builds results per request
// ----------------------------------------------------------------------------
module cbf_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  cbf_pkg::in_req_t raw,
	output cbf_pkg::push_t   push,
	output cbf_pkg::scan_stat_t stat
);
	import cbf_pkg::*;

	logic [7:0] held_byte_q;
	logic       held_valid_q;
	scan_mode_t mode_q;

	cls_t       cls_held;
	cls_t       cls_new;
	scan_mode_t mode_mid;

	always_comb begin
		// held byte sees the incoming byte as lookahead
		cls_held = classify(mode_q, held_byte_q, raw.in_byte, 1'b1);
		mode_mid = held_valid_q ? cls_held.mode : mode_q;
		// final byte has no lookahead
		cls_new  = classify(mode_mid, raw.in_byte, 8'h00, 1'b0);

		if (held_valid_q) begin
			push.item0 = '{out_byte: cls_held.out_byte, out_last: 1'b0};
			push.item1 = '{out_byte: cls_new.out_byte,  out_last: 1'b1};
			push.cnt   = raw.in_last ? 2'd2 : 2'd1;
		end else begin
			push.item0 = '{out_byte: cls_new.out_byte, out_last: 1'b1};
			push.item1 = '{out_byte: cls_new.out_byte, out_last: 1'b1};
			push.cnt   = raw.in_last ? 2'd1 : 2'd0;
		end
		if (!fire) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			mode_q       <= MODE_TEXT;
		end else if (fire) begin
			if (raw.in_last) begin
				held_valid_q <= 1'b0;
				mode_q       <= MODE_TEXT;
			end else begin
				held_byte_q  <= raw.in_byte;
				held_valid_q <= 1'b1;
				mode_q       <= mode_mid;
			end
		end
	end

	assign stat = '{held_valid: held_valid_q, mode: mode_q};

endmodule

// ===== sv/cbf_out_queue.sv =====
// ----------------------------------------------------------------------------
// cbf_out_queue
// three-entry result queue, takes up to two results per cycle
// ----------------------------------------------------------------------------
module cbf_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  cbf_pkg::push_t    push,
	output logic              space,
	output logic [1:0]        level,
	output logic              clean_valid,
	input  logic              clean_ready,
	output cbf_pkg::out_req_t clean
);
	import cbf_pkg::*;

	out_req_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [1:0]        level_q;
	logic [QPTR_W-1:0] wr_nxt;
	logic              pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_nxt = ptr_inc(wr_q);
	assign pop    = clean_valid && clean_ready;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.item0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_nxt] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			unique case (push.cnt)
				2'd1:    wr_q <= wr_nxt;
				2'd2:    wr_q <= ptr_inc(wr_nxt);
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			level_q <= level_q + push.cnt - {1'b0, pop};
		end
	end

	// room for the worst case of two results, regardless of a pop this cycle
	assign space       = (level_q <= 2'd1);
	assign level       = level_q;
	assign clean_valid = (level_q != 2'd0);
	assign clean       = mem_q[rd_q];

endmodule

// ===== verif/comment_blanking_filter_tb.sv =====
// ----------------------------------------------------------------------------
// comment_blanking_filter testbench
// drives text buffers of one byte per request into the filter and checks
// every cleaned byte against a predictor of the blanking rules, under random
// idling on both sides, a long receiver stall and a drain pause
// ----------------------------------------------------------------------------
module testbench;

	import cbf_pkg::*;

	// predictor of the blanking filter plus the queue of cleaned bytes still due
	class blank_scoreboard;
		logic [7:0] held_byte;
		logic       held_valid;
		scan_mode_t mode;
		out_req_t   expected_q[$];
		int         errors;

		function new();
			held_byte  = 8'h00;
			held_valid = 1'b0;
			mode       = MODE_TEXT;
			errors     = 0;
		endfunction

		// cleaned value of one byte given its lookahead, advances the comment mode
		function logic [7:0] blank_byte(logic [7:0] cur, logic [7:0] nxt, logic has_next);
			logic [7:0] res;
			res = cur;
			case (mode)
				MODE_TEXT: begin
					if (cur == CH_SLASH && has_next && (nxt == CH_SLASH || nxt == CH_STAR)) begin
						res  = CH_SPACE;
						mode = (nxt == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
					end
				end
				MODE_LINE: begin
					// the line break itself survives
					if (cur == CH_LF || cur == CH_CR) begin
						mode = MODE_TEXT;
					end else begin
						res = CH_SPACE;
					end
				end
				MODE_BLOCK: begin
					res = CH_SPACE;
					if (cur == CH_STAR && has_next && nxt == CH_SLASH) begin
						mode = MODE_CLOSE;
					end
				end
				default: begin
					// closing slash, blanked and never opens a comment
					res  = CH_SPACE;
					mode = MODE_TEXT;
				end
			endcase
			return res;
		endfunction

		function void note_request(in_req_t r);
			out_req_t e;
			if (held_valid) begin
				e.out_byte = blank_byte(held_byte, r.in_byte, 1'b1);
				e.out_last = 1'b0;
				expected_q.push_back(e);
			end
			if (r.in_last) begin
				// no lookahead past the end of the buffer
				e.out_byte = blank_byte(r.in_byte, 8'h00, 1'b0);
				e.out_last = 1'b1;
				expected_q.push_back(e);
				held_byte  = 8'h00;
				held_valid = 1'b0;
				mode       = MODE_TEXT;
			end else begin
				held_byte  = r.in_byte;
				held_valid = 1'b1;
			end
		endfunction

		function void check_result(out_req_t got);
			out_req_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: out_byte %h out_last %b", got.out_byte, got.out_last);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (got.out_byte !== e.out_byte) begin
					$error("out_byte: expected %h, actual %h", e.out_byte, got.out_byte);
					errors++;
				end
				if (got.out_last !== e.out_last) begin
					$error("out_last: expected %b, actual %b", e.out_last, got.out_last);
					errors++;
				end
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     raw_valid;
	logic     raw_ready;
	in_req_t  raw;
	logic     clean_valid;
	logic     clean_ready;
	out_req_t clean;

	blank_scoreboard sb = new();

	// bookkeeping shared by the sender and the receiver
	int requests_sent = 0;
	bit quiet         = 1'b0;   // no idling on either side while set
	int hold_asked    = 0;      // bumped by the sender to ask for a long stall

	comment_blanking_filter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_valid   (raw_valid),
		.raw_ready   (raw_ready),
		.raw         (raw),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean       (clean)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// one raw request, called at a falling edge and returning at one
	task automatic send_request(logic [7:0] b, logic last);
		// random idle cycles ahead of the request, none in the quiet stretch
		while (!quiet && $urandom_range(0, 99) < 19) begin
			raw_valid = 1'b0;
			@(negedge clk);
		end
		raw.in_byte = b;
		raw.in_last = last;
		raw_valid   = 1'b1;
		@(posedge clk);
		while (!raw_ready) @(posedge clk);
		sb.note_request(raw);
		requests_sent++;
		@(negedge clk);
	endtask

	// a whole buffer from a string, final byte flagged
	task automatic send_buffer(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_request(s[i], i == s.len() - 1);
		end
	endtask

	// hold until every expected cleaned byte has come back
	task automatic drain_results();
		// nothing offered while waiting
		raw_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// random body byte: mostly letters, the comment characters and line breaks,
	// sometimes any byte at all
	function automatic logic [7:0] pick_body();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 8'($urandom_range(0, 255));
			1: return CH_SLASH;
			2: return CH_STAR;
			3: return CH_LF;
			4: return CH_CR;
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// receiver: random ready, a long stall on request, steady ready when quiet
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen   = 0;
		hold_left   = 0;
		clean_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_asked) begin
				// long enough that the result queue fills and raw_ready drops
				hold_seen = hold_asked;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				clean_ready = 1'b0;
				hold_left--;
			end else if (quiet) begin
				clean_ready = 1'b1;
			end else begin
				clean_ready = ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// monitor: every accepted cleaned byte goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && clean_valid && clean_ready) begin
			sb.check_result(clean);
		end
	end

	// stimulus
	initial begin
		logic [7:0] byte_q[$];
		int         n_seg;
		int         kind;
		bit         hold_fired;
		bit         paused;
		hold_fired = 1'b0;
		paused     = 1'b0;
		raw_valid  = 1'b0;
		raw        = '0;
		arst_n     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed buffers
		// single-byte buffer, all ones
		send_request(8'hFF, 1'b1);
		// slash as the final byte has no lookahead and stays a slash
		send_request(8'h00, 1'b0);
		send_request(CH_SLASH, 1'b1);
		// line comment, the LF is kept
		send_buffer("//x\ny");
		// star of the opener closes at once, closing slash does not open again
		send_buffer("/*/*q");
		// line comment ended by CR, then a block comment open at the end
		send_buffer("//\015/*a");
		// empty block comment followed by a lone final slash
		send_buffer("/**//");

		drain_results();

		// random buffers built from text, line and block comments and noise
		while (requests_sent < 1524) begin
			quiet = (requests_sent >= 500 && requests_sent < 800);
			if (!hold_fired && requests_sent >= 250) begin
				hold_asked++;
				hold_fired = 1'b1;
			end
			if (!paused && requests_sent >= 1000) begin
				drain_results();
				paused = 1'b1;
			end
			byte_q.delete();
			n_seg = $urandom_range(1, 4);
			repeat (n_seg) begin
				kind = $urandom_range(0, 9);
				if (kind < 3) begin
					repeat ($urandom_range(0, 5)) byte_q.push_back(pick_body());
				end else if (kind < 6) begin
					byte_q.push_back(CH_SLASH);
					byte_q.push_back(CH_SLASH);
					repeat ($urandom_range(0, 5)) byte_q.push_back(pick_body());
					byte_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
				end else if (kind < 9) begin
					byte_q.push_back(CH_SLASH);
					byte_q.push_back(CH_STAR);
					repeat ($urandom_range(0, 5)) byte_q.push_back(pick_body());
					byte_q.push_back(CH_STAR);
					byte_q.push_back(CH_SLASH);
				end else begin
					// broken pieces around the comment markers
					repeat ($urandom_range(1, 3)) begin
						byte_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
					end
				end
			end
			// cut the tail now and then so comments stay open at the end
			if (byte_q.size() > 1 && $urandom_range(0, 5) == 0) begin
				void'(byte_q.pop_back());
			end
			if (byte_q.size() == 0) begin
				byte_q.push_back(pick_body());
			end
			for (int i = 0; i < byte_q.size(); i++) begin
				send_request(byte_q[i], i == byte_q.size() - 1);
			end
		end
		raw_valid = 1'b0;
		quiet     = 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		// keep the clock running to catch stray results
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog: stops a run that hangs and reports it as failed
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
